>>> src/bhcs_pkg.sv
package bhcs_pkg;

   localparam int unsigned TICKS_PER_WINDOW = 8;
   localparam int unsigned MAX_DUTY         = 100;

   // 1.3738 in unsigned Q16, rounded to nearest.
   localparam logic [16:0] SPEED_FACTOR_Q16 = 17'd90033;
   localparam logic [14:0] SPEED_LIMIT      = 15'h7fff;

   typedef enum logic [1:0] {
      FUNC_HALL  = 2'd0,
      FUNC_TICK  = 2'd1,
      FUNC_SPEED = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_CW   = 2'd1,
      DIR_CCW  = 2'd2
   } dir_type;

   typedef struct packed {
      logic [1:0]         func;
      logic [2:0]         hall;
      logic signed [15:0] speed_value;
   } item_type;

   typedef struct packed {
      logic [6:0]         phase_a_duty;
      logic [6:0]         phase_b_duty;
      logic [6:0]         phase_c_duty;
      logic signed [15:0] measured_speed;
      logic [1:0]         rotation_dir;
   } result_type;

   // Drive pattern for a hall code: bit 2 phase A, bit 1 phase B, bit 0 phase C.
   // Zero means the phases are left as they are.
   function automatic logic [2:0] drive_pattern(dir_type dir, logic [2:0] code);
      logic [2:0] cw;
      logic [2:0] ccw;
      unique case (code)
         3'd1: begin cw = 3'd5; ccw = 3'd2; end
         3'd2: begin cw = 3'd6; ccw = 3'd1; end
         3'd3: begin cw = 3'd4; ccw = 3'd3; end
         3'd4: begin cw = 3'd3; ccw = 3'd4; end
         3'd5: begin cw = 3'd1; ccw = 3'd6; end
         3'd6: begin cw = 3'd2; ccw = 3'd5; end
         default: begin cw = 3'd0; ccw = 3'd0; end
      endcase
      unique case (dir)
         DIR_CW:  return cw;
         DIR_CCW: return ccw;
         default: return 3'd0;
      endcase
   endfunction

endpackage

>>> src/bldc_hall_commutation_speed.sv
// Six-step BLDC commutation with hall sensors and speed measurement.
// Request channel (req_valid, req_stall, req_func, req_hall, req_speed_value)
// carries one beat per event: a hall edge, a speed timer tick or a speed
// command. Response channel (rsp_valid, rsp_stall and the rsp_ fields) returns
// exactly one beat per request, showing the phase duties, measured speed and
// rotation direction after that request has taken effect.
// An accepted request is registered in the input register, then passes
// through the update logic and is registered in the response register.
// Throughput is one beat per cycle while the response is not stalled; the whole update
// is a single pass of logic between those two registers.
// A stalled response is held in the response register; one further request
// is taken into the input register, after which req_stall rises until the
// response is taken. Requests are never dropped.
// Synchronous reset clears both registers' valid flags, sets the direction
// to none and zeroes the duty, phase duties and all counters.
module bldc_hall_commutation_speed #(
   parameter int unsigned TICKS_PER_WINDOW = bhcs_pkg::TICKS_PER_WINDOW
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [2:0]         req_hall,
   input  logic signed [15:0] req_speed_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [6:0]         rsp_phase_a_duty,
   output logic [6:0]         rsp_phase_b_duty,
   output logic [6:0]         rsp_phase_c_duty,
   output logic signed [15:0] rsp_measured_speed,
   output logic [1:0]         rsp_rotation_dir
);

   logic                 s1_valid_ff, s1_valid_in;
   bhcs_pkg::item_type   s1_item_ff;
   logic                 out_valid_ff, out_valid_in;
   bhcs_pkg::result_type out_ff;
   bhcs_pkg::result_type result;
   logic                 out_free;
   logic                 advance;
   logic                 accept;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= '{func: req_func, hall: req_hall, speed_value: req_speed_value};
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   bhcs_core #(
      .TICKS_PER_WINDOW(TICKS_PER_WINDOW)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (s1_item_ff),
      .result (result)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_phase_a_duty   = out_ff.phase_a_duty;
   assign rsp_phase_b_duty   = out_ff.phase_b_duty;
   assign rsp_phase_c_duty   = out_ff.phase_c_duty;
   assign rsp_measured_speed = out_ff.measured_speed;
   assign rsp_rotation_dir   = out_ff.rotation_dir;

   // The input side only stalls while it holds a beat of its own.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stalled with empty input register");

   // A beat that leaves the input register shows up as a response.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed beat lost before the response register");

   // A held response whose beat is not taken keeps the input beat waiting.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && s1_valid_ff |=> s1_valid_ff && $stable(s1_item_ff))
      else $error("input beat moved while the response was stalled");

endmodule

>>> src/bhcs_core.sv
module bhcs_core #(
   parameter int unsigned TICKS_PER_WINDOW = bhcs_pkg::TICKS_PER_WINDOW
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  bhcs_pkg::item_type    item,
   output bhcs_pkg::result_type  result
);

   localparam int unsigned TW = (TICKS_PER_WINDOW > 1) ? $clog2(TICKS_PER_WINDOW) : 1;
   localparam logic [TW-1:0] TICK_LAST = TW'(TICKS_PER_WINDOW - 1);
   localparam logic [16:0]   DUTY_LIMIT = 17'(bhcs_pkg::MAX_DUTY);

   bhcs_pkg::dir_type dir_ff, dir_in;
   logic [6:0]        duty_ff, duty_in;
   logic [6:0]        phase_a_ff, phase_a_in;
   logic [6:0]        phase_b_ff, phase_b_in;
   logic [6:0]        phase_c_ff, phase_c_in;
   logic [15:0]       edge_ff, edge_in;
   logic [14:0]       mag_ff, mag_in;
   logic [TW-1:0]     tick_ff, tick_in;

   logic [32:0]       speed_product;
   logic [16:0]       speed_scaled;
   logic [14:0]       speed_mag;
   logic [16:0]       cmd_mag;
   logic              do_commutate;
   logic [2:0]        pattern;
   logic [15:0]       mag_ext;

   // The speed magnitude is worked out from the running count and kept
   // ready, so that a window close only has to load it.
   assign speed_product = {17'd0, edge_ff} * {16'd0, bhcs_pkg::SPEED_FACTOR_Q16};
   assign speed_scaled  = speed_product[32:16];
   assign speed_mag     = (speed_scaled > {2'd0, bhcs_pkg::SPEED_LIMIT}) ?
                          bhcs_pkg::SPEED_LIMIT : speed_scaled[14:0];

   always_comb begin
      dir_in       = dir_ff;
      duty_in      = duty_ff;
      phase_a_in   = phase_a_ff;
      phase_b_in   = phase_b_ff;
      phase_c_in   = phase_c_ff;
      edge_in      = edge_ff;
      mag_in       = mag_ff;
      tick_in      = tick_ff;
      cmd_mag      = 17'd0;
      do_commutate = 1'b0;
      pattern      = 3'd0;
      if (fire) begin
         unique case (item.func)
            bhcs_pkg::FUNC_HALL: begin
               do_commutate = 1'b1;
            end
            bhcs_pkg::FUNC_TICK: begin
               if (tick_ff == TICK_LAST) begin
                  tick_in = '0;
                  edge_in = 16'd0;
                  mag_in  = speed_mag;
               end else begin
                  tick_in = tick_ff + TW'(1);
               end
            end
            bhcs_pkg::FUNC_SPEED: begin
               if (item.speed_value[15]) begin
                  dir_in  = bhcs_pkg::DIR_CCW;
                  cmd_mag = 17'h10000 - {1'b0, item.speed_value};
               end else begin
                  if (item.speed_value != 16'sd0) begin
                     dir_in = bhcs_pkg::DIR_CW;
                  end
                  cmd_mag = {1'b0, item.speed_value};
               end
               duty_in = (cmd_mag > DUTY_LIMIT) ? DUTY_LIMIT[6:0] : cmd_mag[6:0];
               // A stopped motor gets its first commutation straight away.
               if (dir_in == bhcs_pkg::DIR_NONE || mag_ff == 15'd0) begin
                  do_commutate = 1'b1;
               end
            end
            default: begin
            end
         endcase
         if (do_commutate) begin
            edge_in = edge_ff + 16'd1;
            pattern = bhcs_pkg::drive_pattern(dir_in, item.hall);
            if (pattern != 3'd0) begin
               phase_a_in = pattern[2] ? duty_in : 7'd0;
               phase_b_in = pattern[1] ? duty_in : 7'd0;
               phase_c_in = pattern[0] ? duty_in : 7'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff     <= bhcs_pkg::DIR_NONE;
         duty_ff    <= 7'd0;
         phase_a_ff <= 7'd0;
         phase_b_ff <= 7'd0;
         phase_c_ff <= 7'd0;
         edge_ff    <= 16'd0;
         mag_ff     <= 15'd0;
         tick_ff    <= '0;
      end else begin
         dir_ff     <= dir_in;
         duty_ff    <= duty_in;
         phase_a_ff <= phase_a_in;
         phase_b_ff <= phase_b_in;
         phase_c_ff <= phase_c_in;
         edge_ff    <= edge_in;
         mag_ff     <= mag_in;
         tick_ff    <= tick_in;
      end
   end

   assign mag_ext = {1'b0, mag_in};

   always_comb begin
      result.phase_a_duty = phase_a_in;
      result.phase_b_duty = phase_b_in;
      result.phase_c_duty = phase_c_in;
      result.rotation_dir = dir_in;
      unique case (dir_in)
         bhcs_pkg::DIR_CW:  result.measured_speed = $signed(mag_ext);
         bhcs_pkg::DIR_CCW: result.measured_speed = -$signed(mag_ext);
         default:           result.measured_speed = 16'sd0;
      endcase
   end

   // Once a direction is set it is never cleared again.
   assert property (@(posedge clock) disable iff (reset)
      dir_ff != bhcs_pkg::DIR_NONE |=> dir_ff != bhcs_pkg::DIR_NONE)
      else $error("direction returned to none");

   // Closing a window restarts the commutation count.
   assert property (@(posedge clock) disable iff (reset)
      fire && item.func == bhcs_pkg::FUNC_TICK && tick_ff == TICK_LAST
      |=> edge_ff == 16'd0 && tick_ff == '0)
      else $error("window close did not clear the counters");

   // Without an item nothing in the state moves.
   assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(edge_ff) && $stable(tick_ff) && $stable(duty_ff)
                && $stable(mag_ff))
      else $error("state changed without an item");

   // The tick counter stays inside its window.
   assert property (@(posedge clock) disable iff (reset)
      tick_ff <= TICK_LAST)
      else $error("tick counter beyond window");

endmodule

>>> test/bhcs_drive_checker.sv
module bhcs_drive_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [2:0]         req_hall,
   input  logic signed [15:0] req_speed_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [6:0]         rsp_phase_a_duty,
   input  logic [6:0]         rsp_phase_b_duty,
   input  logic [6:0]         rsp_phase_c_duty,
   input  logic signed [15:0] rsp_measured_speed,
   input  logic [1:0]         rsp_rotation_dir,
   output int                 fail_count,
   output int                 pending
);

   // Drive patterns indexed by hall code, three bits per code, code 7 at the top.
   // Bit 2 drives phase A, bit 1 phase B, bit 0 phase C.
   localparam logic [23:0] CW_PATTERNS  = {3'd0, 3'd2, 3'd1, 3'd3, 3'd4, 3'd6, 3'd5, 3'd0};
   localparam logic [23:0] CCW_PATTERNS = {3'd0, 3'd5, 3'd6, 3'd4, 3'd3, 3'd1, 3'd2, 3'd0};

   bhcs_pkg::dir_type     drive_dir;
   logic [6:0]            duty_level;
   logic [6:0]            phase_level [3];
   logic [15:0]           edge_tally;
   logic [15:0]           window_tally;
   int unsigned           tick_tally;
   int                    mismatches = 0;
   bhcs_pkg::result_type  drive_reports [$];

   function automatic logic signed [15:0] speed_reading();
      logic [32:0] product;
      logic [15:0] magnitude;
      product = ({17'd0, window_tally} * {16'd0, bhcs_pkg::SPEED_FACTOR_Q16}) >> 16;
      if (product > 33'd32767) begin
         magnitude = 16'h7fff;
      end else begin
         magnitude = product[15:0];
      end
      case (drive_dir)
         bhcs_pkg::DIR_CW:  return magnitude;
         bhcs_pkg::DIR_CCW: return -magnitude;
         default:           return 16'sd0;
      endcase
   endfunction

   task automatic step_commutation(logic [2:0] code);
      logic [2:0] pattern;
      edge_tally = edge_tally + 16'd1;
      case (drive_dir)
         bhcs_pkg::DIR_CW:  pattern = CW_PATTERNS[code * 3 +: 3];
         bhcs_pkg::DIR_CCW: pattern = CCW_PATTERNS[code * 3 +: 3];
         default:           pattern = 3'd0;
      endcase
      // Codes with no valid pattern leave the phases as they were.
      if (pattern != 3'd0 && pattern != 3'd7) begin
         phase_level[0] = pattern[2] ? duty_level : 7'd0;
         phase_level[1] = pattern[1] ? duty_level : 7'd0;
         phase_level[2] = pattern[0] ? duty_level : 7'd0;
      end
   endtask

   task automatic predict_beat(logic [1:0] func, logic [2:0] hall, logic [15:0] speed);
      logic [16:0]          magnitude;
      bhcs_pkg::result_type report;
      case (func)
         bhcs_pkg::FUNC_HALL: begin
            step_commutation(hall);
         end
         bhcs_pkg::FUNC_TICK: begin
            tick_tally++;
            if (tick_tally >= bhcs_pkg::TICKS_PER_WINDOW) begin
               tick_tally   = 0;
               window_tally = edge_tally;
               edge_tally   = 16'd0;
            end
         end
         bhcs_pkg::FUNC_SPEED: begin
            if (speed[15]) begin
               drive_dir = bhcs_pkg::DIR_CCW;
               magnitude = 17'h10000 - {1'b0, speed};
            end else begin
               // A zero command keeps whatever direction was set before.
               if (speed != 16'd0) begin
                  drive_dir = bhcs_pkg::DIR_CW;
               end
               magnitude = {1'b0, speed};
            end
            if (magnitude > 17'(bhcs_pkg::MAX_DUTY)) begin
               magnitude = 17'(bhcs_pkg::MAX_DUTY);
            end
            duty_level = magnitude[6:0];
            if (speed_reading() == 16'sd0) begin
               step_commutation(hall);
            end
         end
         default: ;
      endcase
      report.phase_a_duty   = phase_level[0];
      report.phase_b_duty   = phase_level[1];
      report.phase_c_duty   = phase_level[2];
      report.measured_speed = speed_reading();
      report.rotation_dir   = drive_dir;
      drive_reports.push_back(report);
   endtask

   task automatic check_field(string name, logic signed [16:0] expected,
                              logic signed [16:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, expected, actual);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      bhcs_pkg::result_type oldest;
      if (reset) begin
         drive_dir    = bhcs_pkg::DIR_NONE;
         duty_level   = 7'd0;
         phase_level  = '{7'd0, 7'd0, 7'd0};
         edge_tally   = 16'd0;
         window_tally = 16'd0;
         tick_tally   = 0;
         drive_reports.delete();
      end else begin
         if (req_valid && !req_stall) begin
            predict_beat(req_func, req_hall, req_speed_value);
         end
         if (rsp_valid && !rsp_stall) begin
            if (drive_reports.size() == 0) begin
               $display("%0t: response beat arrived with no prediction waiting", $time);
               mismatches++;
            end else begin
               oldest = drive_reports.pop_front();
               check_field("phase A duty", {10'd0, oldest.phase_a_duty},
                           {10'd0, rsp_phase_a_duty});
               check_field("phase B duty", {10'd0, oldest.phase_b_duty},
                           {10'd0, rsp_phase_b_duty});
               check_field("phase C duty", {10'd0, oldest.phase_c_duty},
                           {10'd0, rsp_phase_c_duty});
               check_field("measured speed",
                           {oldest.measured_speed[15], oldest.measured_speed},
                           {rsp_measured_speed[15], rsp_measured_speed});
               check_field("rotation direction", {15'd0, oldest.rotation_dir},
                           {15'd0, rsp_rotation_dir});
            end
         end
      end
      fail_count <= mismatches;
      pending    <= drive_reports.size();
   end

endmodule

>>> test/bldc_hall_commutation_speed_tb.sv
module bldc_hall_commutation_speed_tb;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int         STUCK_LIMIT = 5000;
   localparam int         PHASE_BEATS = 500;

   logic               clock;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_stall;
   logic [1:0]         req_func        = bhcs_pkg::FUNC_HALL;
   logic [2:0]         req_hall        = 3'd0;
   logic signed [15:0] req_speed_value = 16'sd0;
   logic               rsp_valid;
   logic               rsp_stall       = 1'b0;
   logic [6:0]         rsp_phase_a_duty;
   logic [6:0]         rsp_phase_b_duty;
   logic [6:0]         rsp_phase_c_duty;
   logic signed [15:0] rsp_measured_speed;
   logic [1:0]         rsp_rotation_dir;

   int fail_count;
   int pending;
   int send_idle = 22;
   int recv_idle = 64;
   int stuck_cycles = 0;
   int beats_sent;

   bldc_hall_commutation_speed uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_hall           (req_hall),
      .req_speed_value    (req_speed_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_phase_a_duty   (rsp_phase_a_duty),
      .rsp_phase_b_duty   (rsp_phase_b_duty),
      .rsp_phase_c_duty   (rsp_phase_c_duty),
      .rsp_measured_speed (rsp_measured_speed),
      .rsp_rotation_dir   (rsp_rotation_dir)
   );

   bhcs_drive_checker drive_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_hall           (req_hall),
      .req_speed_value    (req_speed_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_phase_a_duty   (rsp_phase_a_duty),
      .rsp_phase_b_duty   (rsp_phase_b_duty),
      .rsp_phase_c_duty   (rsp_phase_c_duty),
      .rsp_measured_speed (rsp_measured_speed),
      .rsp_rotation_dir   (rsp_rotation_dir),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_beat(logic [1:0] func, logic [2:0] hall, logic [15:0] speed);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= func;
      req_hall        <= hall;
      req_speed_value <= speed;
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   // Holds the request side quiet until every predicted response has been taken.
   task automatic drain_reports();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic random_sequence();
      int         count;
      int         signed_speed;
      logic [2:0] code;
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            count = $urandom_range(1, 12);
            repeat (count) begin
               code = ($urandom_range(7) == 0) ? 3'($urandom_range(7))
                                               : 3'($urandom_range(1, 6));
               send_beat(bhcs_pkg::FUNC_HALL, code, 16'($urandom));
            end
         end
         4, 5: begin
            count = $urandom_range(1, 9);
            repeat (count) send_beat(bhcs_pkg::FUNC_TICK, 3'($urandom), 16'($urandom));
         end
         6: begin
            signed_speed = $urandom_range(240) - 120;
            send_beat(bhcs_pkg::FUNC_SPEED, 3'($urandom), signed_speed[15:0]);
         end
         7: send_beat(bhcs_pkg::FUNC_SPEED, 3'($urandom), 16'($urandom));
         8: send_beat(2'($urandom), 3'($urandom), 16'($urandom));
         default: send_beat(bhcs_pkg::FUNC_SPEED, 3'($urandom), 16'd0);
      endcase
   endtask

   task automatic random_phase();
      beats_sent = 0;
      while (beats_sent < PHASE_BEATS) random_sequence();
   endtask

   // A long run of hall edges inside one window, then enough ticks to close it.
   task automatic edge_burst(int edges);
      repeat (edges) send_beat(bhcs_pkg::FUNC_HALL, 3'($urandom_range(7)), 16'($urandom));
      repeat (bhcs_pkg::TICKS_PER_WINDOW) begin
         send_beat(bhcs_pkg::FUNC_TICK, 3'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Before any direction exists, edges are counted but drive nothing.
      send_beat(bhcs_pkg::FUNC_HALL, 3'd3, 16'h0000);
      send_beat(bhcs_pkg::FUNC_SPEED, 3'd5, 16'h0000);
      send_beat(bhcs_pkg::FUNC_SPEED, 3'd1, 16'd50);
      send_beat(bhcs_pkg::FUNC_HALL, 3'd0, 16'hffff);
      send_beat(bhcs_pkg::FUNC_HALL, 3'd7, 16'h0000);
      for (int code = 1; code <= 6; code++) begin
         send_beat(bhcs_pkg::FUNC_HALL, 3'(code), 16'h0000);
      end
      repeat (bhcs_pkg::TICKS_PER_WINDOW) send_beat(bhcs_pkg::FUNC_TICK, 3'd0, 16'h0000);
      send_beat(bhcs_pkg::FUNC_SPEED, 3'd2, 16'h8000);
      send_beat(bhcs_pkg::FUNC_HALL, 3'd6, 16'h0000);
      send_beat(bhcs_pkg::FUNC_SPEED, 3'd4, 16'h7fff);
      send_beat(bhcs_pkg::FUNC_HALL, 3'd2, 16'h0000);
      send_beat(bhcs_pkg::FUNC_SPEED, 3'd3, 16'hffff);
      send_beat(bhcs_pkg::FUNC_SPEED, 3'd5, 16'h0000);
      send_beat(FUNC_UNUSED, 3'd7, 16'h7fff);
      send_beat(bhcs_pkg::FUNC_HALL, 3'd4, 16'h0000);
      drain_reports();

      random_phase();
      drain_reports();

      send_idle = 64;
      recv_idle = 22;
      random_phase();
      drain_reports();

      send_idle = 0;
      recv_idle = 0;
      random_phase();
      // Many edges in one window give a large speed reading in both directions.
      send_beat(bhcs_pkg::FUNC_SPEED, 3'd1, 16'd60);
      edge_burst(150);
      send_beat(bhcs_pkg::FUNC_SPEED, 3'd2, -16'sd50);
      send_beat(bhcs_pkg::FUNC_SPEED, 3'd3, 16'd70);
      send_beat(bhcs_pkg::FUNC_SPEED, 3'd6, -16'sd3);
      drain_reports();

      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
